/* sv/rom_melody_square_generator_assert.svh */
// Assertion macros shared by the melody generator modules.
`ifndef ROM_MELODY_SQUARE_GENERATOR_ASSERT_SVH
`define ROM_MELODY_SQUARE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RMSG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RMSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rmsg_pkg.sv */
// Types and constants of the melody square generator.
package rmsg_pkg;

    localparam int MELODY_DEPTH_DEF = 2048;
    localparam int PITCH_DEPTH_DEF  = 32;

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int ADDR_LO_W = 7;

    // control byte bits
    localparam int BIT_HOLD      = 4;
    localparam int BIT_AUTO      = 5;
    localparam int BIT_MAN_CLK   = 6;
    // latched melody byte bit: timer running
    localparam int BIT_TIMER_RUN = 5;

    localparam logic [DATA_W-1:0] QUIET_RELOAD = 8'hff;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CTRL       = 3'd0,
        FUNC_AUTO       = 3'd1,
        FUNC_SAMPLE     = 3'd2,
        FUNC_LOAD_MEL   = 3'd3,
        FUNC_LOAD_PITCH = 3'd4
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] data;
        logic [ADDR_W-1:0] load_address;
    } t_in_word;

    typedef struct packed {
        logic              audio_level;
        logic [DATA_W-1:0] melody_byte;
        logic [ADDR_W-1:0] melody_address;
    } t_out_word;

    // state visible right after an item has been processed
    typedef struct packed {
        logic              square;
        logic [ADDR_W-1:0] addr;
    } t_state;

endpackage

/* sv/rmsg_if.sv */
// Handshake channels of the melody square generator.
interface rmsg_in_if;
    logic                          valid;
    logic                          ready;
    logic [rmsg_pkg::FUNC_W-1:0]   func;
    logic [rmsg_pkg::DATA_W-1:0]   data;
    logic [rmsg_pkg::ADDR_W-1:0]   load_address;

    modport source (output valid, output func, output data, output load_address,
                    input ready);
    modport sink   (input valid, input func, input data, input load_address,
                    output ready);
endinterface

interface rmsg_out_if;
    logic                          valid;
    logic                          ready;
    logic                          audio_level;
    logic [rmsg_pkg::DATA_W-1:0]   melody_byte;
    logic [rmsg_pkg::ADDR_W-1:0]   melody_address;

    modport source (output valid, output audio_level, output melody_byte,
                    output melody_address, input ready);
    modport sink   (input valid, input audio_level, input melody_byte,
                    input melody_address, output ready);
endinterface

/* sv/rmsg_melody_ram.sv */
// Melody store: single write port, registered read port.
module rmsg_melody_ram #(
    parameter int DEPTH = rmsg_pkg::MELODY_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [rmsg_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [rmsg_pkg::DATA_W-1:0] o_rdata
);

    logic [rmsg_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [rmsg_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rmsg_engine.sv */
// Control latch, address counter, pitch divider, pitch store and melody store.
`include "rom_melody_square_generator_assert.svh"

module rmsg_engine #(
    parameter int MELODY_DEPTH = rmsg_pkg::MELODY_DEPTH_DEF,
    parameter int PITCH_DEPTH  = rmsg_pkg::PITCH_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  rmsg_pkg::t_in_word          i_item,
    output rmsg_pkg::t_state            o_state,
    output logic [rmsg_pkg::DATA_W-1:0] o_latched
);

    localparam int MAW = $clog2(MELODY_DEPTH);
    localparam int PAW = $clog2(PITCH_DEPTH);
    localparam int AW  = rmsg_pkg::ADDR_W;
    localparam int LW  = rmsg_pkg::ADDR_LO_W;
    localparam int DW  = rmsg_pkg::DATA_W;

    logic [DW-1:0] r_ctrl, n_ctrl;
    logic [AW-1:0] r_addr, n_addr;
    logic [DW-1:0] r_div,  n_div;
    logic          r_sq,   n_sq;
    logic [DW-1:0] r_latched;
    logic          r_pend, n_pend;
    logic [DW-1:0] r_pitch [PITCH_DEPTH];

    logic [DW-1:0] w_mem_q;
    logic [DW-1:0] w_lat;
    logic [DW-1:0] w_changed;
    logic [AW-1:0] w_caddr;
    logic [DW-1:0] w_div;
    logic          w_mel_we;

    function automatic logic [AW-1:0] f_step(input logic [AW-1:0] a);
        logic [LW-1:0] lo;
        lo = a[LW-1:0] + LW'(1);
        return {a[AW-1:LW], lo};
    endfunction

    // byte of the previous relatch arrives from the RAM read register in the cycle after the relatch
    assign w_lat = r_pend ? w_mem_q : r_latched;

    always_comb begin
        n_ctrl    = r_ctrl;
        n_addr    = r_addr;
        n_div     = r_div;
        n_sq      = r_sq;
        n_pend    = 1'b0;
        w_changed = i_item.data ^ r_ctrl;
        w_caddr   = {i_item.data[AW-LW-1:0], r_addr[LW-1:0]};
        w_div     = r_div + DW'(1);
        w_mel_we  = 1'b0;
        if (i_fire) begin
            case (i_item.func)
                rmsg_pkg::FUNC_CTRL: begin
                    n_ctrl = i_item.data;
                    if (i_item.data[rmsg_pkg::BIT_HOLD]) begin
                        w_caddr[LW-1:0] = '0;
                        n_sq            = 1'b0;
                    end
                    // manual step on a rising edge, only in manual mode and not held
                    if (w_changed[rmsg_pkg::BIT_MAN_CLK] && i_item.data[rmsg_pkg::BIT_MAN_CLK]
                        && !i_item.data[rmsg_pkg::BIT_AUTO]
                        && !i_item.data[rmsg_pkg::BIT_HOLD]) begin
                        w_caddr = f_step(w_caddr);
                    end
                    n_addr = w_caddr;
                    n_pend = 1'b1;
                end
                rmsg_pkg::FUNC_AUTO: begin
                    if (w_lat[rmsg_pkg::BIT_TIMER_RUN] && r_ctrl[rmsg_pkg::BIT_AUTO]
                        && !r_ctrl[rmsg_pkg::BIT_HOLD]) begin
                        n_addr = f_step(r_addr);
                        n_pend = 1'b1;
                    end
                end
                rmsg_pkg::FUNC_SAMPLE: begin
                    if (!r_ctrl[rmsg_pkg::BIT_HOLD]) begin
                        if (w_div == '0) begin
                            w_div = r_pitch[w_lat[PAW-1:0]];
                            if (w_div != rmsg_pkg::QUIET_RELOAD) begin
                                n_sq = ~r_sq;
                            end
                        end
                        n_div = w_div;
                    end
                end
                rmsg_pkg::FUNC_LOAD_MEL: begin
                    w_mel_we = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= '0;
            r_addr    <= '0;
            r_div     <= '0;
            r_sq      <= 1'b0;
            r_latched <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_ctrl    <= n_ctrl;
            r_addr    <= n_addr;
            r_div     <= n_div;
            r_sq      <= n_sq;
            r_latched <= w_lat;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_item.func == rmsg_pkg::FUNC_LOAD_PITCH) begin
            r_pitch[i_item.load_address[PAW-1:0]] <= i_item.data;
        end
    end

    rmsg_melody_ram #(
        .DEPTH (MELODY_DEPTH),
        .AW    (MAW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mel_we),
        .i_waddr (i_item.load_address[MAW-1:0]),
        .i_wdata (i_item.data),
        .i_raddr (n_addr[MAW-1:0]),
        .o_rdata (w_mem_q)
    );

    assign o_state.square = n_sq;
    assign o_state.addr   = n_addr;
    assign o_latched      = w_lat;

    `RMSG_ASSERT_NEXT(a_hold_clears, i_clk, i_rst_n, i_fire && i_item.func == rmsg_pkg::FUNC_CTRL && i_item.data[rmsg_pkg::BIT_HOLD], !r_sq && r_addr[LW-1:0] == '0 && r_pend, "hold write did not clear square and low address")
    `RMSG_ASSERT_NEXT(a_load_keeps, i_clk, i_rst_n, i_fire && (i_item.func == rmsg_pkg::FUNC_LOAD_MEL || i_item.func == rmsg_pkg::FUNC_LOAD_PITCH), $stable(r_addr) && !r_pend && $stable(r_sq), "store load changed address or relatched")
    `RMSG_ASSERT_NEXT(a_pend_src, i_clk, i_rst_n, !i_fire, !r_pend && $stable(r_addr), "relatch pending without a processed word")

endmodule

/* sv/rom_melody_square_generator.sv */
// Top level of the melody square generator: handshake stages around the engine.
//
// Takes one word per clock on i_in while o_out is not stalled and returns one result word
// per input word on o_out, in order. A word first lands in an input register; as it moves
// to the middle register, the engine updates the control latch, the melody address, the
// pitch divider and the square flag and launches the melody RAM read for the new address;
// the result then sits in the middle register while the RAM data arrives and is forwarded
// as the latched byte, and moves to the output register. The loop that sets the rate is
// address -> registered melody RAM read -> latched byte -> next address, closed by
// forwarding the RAM output into the next word's step, so it holds one word per cycle. Each
// stage moves when the stage after it is empty or moving, so input words are still taken
// while a result waits on o_out. The melody store (2048 x 8) and pitch store (32 x 8) come
// out of reset unwritten and need no clearing pass; the block is ready right after reset.
`include "rom_melody_square_generator_assert.svh"

module rom_melody_square_generator #(
    parameter int MELODY_DEPTH = rmsg_pkg::MELODY_DEPTH_DEF,
    parameter int PITCH_DEPTH  = rmsg_pkg::PITCH_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rmsg_in_if.sink           i_in,
    rmsg_out_if.source        o_out
);

    // pipeline valids
    logic r_in_v, r_mid_v, r_out_v;
    // stage moves
    logic w_en_in, w_en_mid, w_en_out, w_fire;

    rmsg_pkg::t_in_word  r_in;
    rmsg_pkg::t_state    r_mid;
    rmsg_pkg::t_out_word r_out;

    rmsg_pkg::t_state            w_state;
    logic [rmsg_pkg::DATA_W-1:0] w_latched;

    assign w_en_out = !r_out_v || o_out.ready;
    assign w_en_mid = !r_mid_v || w_en_out;
    assign w_en_in  = !r_in_v  || w_en_mid;
    // word in the input register is processed as it moves to the middle stage
    assign w_fire   = r_in_v && w_en_mid;

    assign i_in.ready = w_en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en_in) begin
                r_in_v <= i_in.valid;
            end
            if (w_en_mid) begin
                r_mid_v <= r_in_v;
            end
            if (w_en_out) begin
                r_out_v <= r_mid_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_in && i_in.valid) begin
            r_in.func         <= i_in.func;
            r_in.data         <= i_in.data;
            r_in.load_address <= i_in.load_address;
        end
        if (w_fire) begin
            r_mid <= w_state;
        end
        // latched byte of the middle word is valid exactly while it sits there
        if (w_en_out && r_mid_v) begin
            r_out.audio_level    <= r_mid.square;
            r_out.melody_byte    <= w_latched;
            r_out.melody_address <= r_mid.addr;
        end
    end

    rmsg_engine #(
        .MELODY_DEPTH (MELODY_DEPTH),
        .PITCH_DEPTH  (PITCH_DEPTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_item    (r_in),
        .o_state   (w_state),
        .o_latched (w_latched)
    );

    assign o_out.valid          = r_out_v;
    assign o_out.audio_level    = r_out.audio_level;
    assign o_out.melody_byte    = r_out.melody_byte;
    assign o_out.melody_address = r_out.melody_address;

    `RMSG_ASSERT_NEXT(a_mid_holds, i_clk, i_rst_n, r_mid_v && !w_en_out,
        r_mid_v && $stable(r_mid) && $stable(w_latched), "middle word changed while stalled")
    `RMSG_ASSERT_SAME(a_no_fire_stall, i_clk, i_rst_n, r_mid_v && !w_en_out, !w_fire,
        "word processed into a stalled middle stage")

endmodule

/* tb/rom_melody_square_generator_tb.sv */
// Melody square generator testbench: directed and random words checked against a predictor.
module rom_melody_square_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [$clog2(rmsg_pkg::PITCH_DEPTH_DEF)-1:0] t_pitch_idx;

    typedef struct packed {
        logic [rmsg_pkg::DATA_W-1:0] ctrl;
        logic [rmsg_pkg::ADDR_W-1:0] addr;
        logic [rmsg_pkg::DATA_W-1:0] latched;
        logic [rmsg_pkg::DATA_W-1:0] divider;
        logic                        square;
    } t_gen_regs;

    class melody_scoreboard;
        t_gen_regs                   regs;
        logic [rmsg_pkg::DATA_W-1:0] melody_mem [rmsg_pkg::MELODY_DEPTH_DEF];
        bit                          melody_set [rmsg_pkg::MELODY_DEPTH_DEF];
        logic [rmsg_pkg::DATA_W-1:0] pitch_mem  [rmsg_pkg::PITCH_DEPTH_DEF];
        bit                          pitch_set  [rmsg_pkg::PITCH_DEPTH_DEF];
        rmsg_pkg::t_out_word         expected_words [$];
        int                          errors;
        int                          checked;
        int                          toggles;

        function new();
            regs    = '0;
            errors  = 0;
            checked = 0;
            toggles = 0;
            foreach (melody_mem[i]) begin
                melody_mem[i] = '0;
                melody_set[i] = 1'b0;
            end
            foreach (pitch_mem[i]) begin
                pitch_mem[i] = '0;
                pitch_set[i] = 1'b0;
            end
        endfunction

        // Register update for one word. Also tells which store entry it reads, so the
        // stimulus can write that entry first. Store loads leave the registers alone.
        function t_gen_regs next_state(t_gen_regs r, rmsg_pkg::t_in_word w,
                                       output bit mel_rd,
                                       output logic [rmsg_pkg::ADDR_W-1:0] mel_a,
                                       output bit pit_rd, output t_pitch_idx pit_i);
            logic [rmsg_pkg::DATA_W-1:0] changed;
            mel_rd = 1'b0;
            mel_a  = '0;
            pit_rd = 1'b0;
            pit_i  = '0;
            case (w.func)
                rmsg_pkg::FUNC_CTRL: begin
                    changed = w.data ^ r.ctrl;
                    r.ctrl  = w.data;
                    r.addr[rmsg_pkg::ADDR_W-1:rmsg_pkg::ADDR_LO_W] =
                        w.data[rmsg_pkg::ADDR_W-rmsg_pkg::ADDR_LO_W-1:0];
                    if (w.data[rmsg_pkg::BIT_HOLD]) begin
                        r.addr[rmsg_pkg::ADDR_LO_W-1:0] = '0;
                        r.square = 1'b0;
                    end
                    if (changed[rmsg_pkg::BIT_MAN_CLK] && w.data[rmsg_pkg::BIT_MAN_CLK] &&
                        !w.data[rmsg_pkg::BIT_AUTO] && !w.data[rmsg_pkg::BIT_HOLD])
                        r.addr[rmsg_pkg::ADDR_LO_W-1:0] =
                            r.addr[rmsg_pkg::ADDR_LO_W-1:0] + 1'b1;
                    mel_rd    = 1'b1;
                    mel_a     = r.addr;
                    r.latched = melody_mem[r.addr];
                end
                rmsg_pkg::FUNC_AUTO: begin
                    if (r.latched[rmsg_pkg::BIT_TIMER_RUN] && r.ctrl[rmsg_pkg::BIT_AUTO] &&
                        !r.ctrl[rmsg_pkg::BIT_HOLD]) begin
                        r.addr[rmsg_pkg::ADDR_LO_W-1:0] =
                            r.addr[rmsg_pkg::ADDR_LO_W-1:0] + 1'b1;
                        mel_rd    = 1'b1;
                        mel_a     = r.addr;
                        r.latched = melody_mem[r.addr];
                    end
                end
                rmsg_pkg::FUNC_SAMPLE: begin
                    if (!r.ctrl[rmsg_pkg::BIT_HOLD]) begin
                        r.divider = r.divider + 1'b1;
                        if (r.divider == '0) begin
                            pit_rd    = 1'b1;
                            pit_i     = r.latched[$bits(t_pitch_idx)-1:0];
                            r.divider = pitch_mem[pit_i];
                            if (r.divider != rmsg_pkg::QUIET_RELOAD)
                                r.square = ~r.square;
                        end
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_word(rmsg_pkg::t_in_word w);
            t_gen_regs                   nxt;
            bit                          mr;
            bit                          pr;
            logic [rmsg_pkg::ADDR_W-1:0] ma;
            t_pitch_idx                  pi;
            rmsg_pkg::t_out_word         want;
            case (w.func)
                rmsg_pkg::FUNC_LOAD_MEL: begin
                    melody_mem[w.load_address] = w.data;
                    melody_set[w.load_address] = 1'b1;
                end
                rmsg_pkg::FUNC_LOAD_PITCH: begin
                    pitch_mem[w.load_address[$bits(t_pitch_idx)-1:0]] = w.data;
                    pitch_set[w.load_address[$bits(t_pitch_idx)-1:0]] = 1'b1;
                end
                default: begin
                    nxt = next_state(regs, w, mr, ma, pr, pi);
                    if (nxt.square != regs.square)
                        toggles++;
                    regs = nxt;
                end
            endcase
            want.audio_level    = regs.square;
            want.melody_byte    = regs.latched;
            want.melody_address = regs.addr;
            expected_words.push_back(want);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at result %0d: %s", checked, what);
            errors++;
        endtask

        task check_result(rmsg_pkg::t_out_word got);
            rmsg_pkg::t_out_word want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result word with nothing pending: %p", got));
                return;
            end
            want = expected_words.pop_front();
            checked++;
            if (got.audio_level !== want.audio_level)
                report_mismatch($sformatf("audio_level got %b want %b",
                                          got.audio_level, want.audio_level));
            if (got.melody_byte !== want.melody_byte)
                report_mismatch($sformatf("melody_byte got %h want %h",
                                          got.melody_byte, want.melody_byte));
            if (got.melody_address !== want.melody_address)
                report_mismatch($sformatf("melody_address got %h want %h",
                                          got.melody_address, want.melody_address));
        endtask
    endclass

    // Func codes the block ignores
    localparam logic [rmsg_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
    localparam logic [rmsg_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
    localparam logic [rmsg_pkg::FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

    localparam int WORDS_PER_PHASE = 170;  // random words per pacing phase
    localparam int LONG_HOLD_OFF   = 60;   // receiver back-pressure stretch, cycles
    localparam int DRAIN_CYCLES    = 16;   // pipeline is three deep, leave margin
    localparam int TIMEOUT_NS      = 2_000_000;

    logic i_clk;
    logic i_rst_n;

    rmsg_in_if  in_ch ();
    rmsg_out_if out_ch ();

    rom_melody_square_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    melody_scoreboard sb;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_off_left      = 0;
    int words_sent         = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake hangs.
    initial begin
        #TIMEOUT_NS;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: ready changes on the falling edge. A long hold-off, when requested,
    // is counted down here so the sender keeps pushing and the pipe backs up.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                out_ch.ready = 1'b0;
                hold_off_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Both channels are sampled at the rising edge, where the handshakes complete.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_word(rmsg_pkg::t_in_word'{in_ch.func, in_ch.data,
                                                  in_ch.load_address});
            if (out_ch.valid && out_ch.ready)
                sb.check_result(rmsg_pkg::t_out_word'{out_ch.audio_level,
                                                      out_ch.melody_byte,
                                                      out_ch.melody_address});
        end
    end

    // Pitch reloads near the top keep the square toggling every few sample ticks.
    function automatic logic [rmsg_pkg::DATA_W-1:0] random_pitch();
        if ($urandom_range(3) != 0)
            return rmsg_pkg::DATA_W'($urandom_range(8'hff, 8'he0));
        return rmsg_pkg::DATA_W'($urandom);
    endfunction

    // One word on the input channel. Entered and left on a falling edge; valid stays
    // high into the next call, which may drop it for idle cycles.
    task automatic send_word(logic [rmsg_pkg::FUNC_W-1:0] f, logic [rmsg_pkg::DATA_W-1:0] d,
                             logic [rmsg_pkg::ADDR_W-1:0] a);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.func         = f;
        in_ch.data         = d;
        in_ch.load_address = a;
        forever begin
            @(posedge i_clk);
            if (in_ch.ready)
                break;
        end
        @(negedge i_clk);
        words_sent++;
    endtask

    // Sends a word, first loading any store entry it would read that was never
    // written. Predictor state is current here: every earlier word was noted at
    // the rising edge before this falling edge.
    task automatic send_item(logic [rmsg_pkg::FUNC_W-1:0] f, logic [rmsg_pkg::DATA_W-1:0] d,
                             logic [rmsg_pkg::ADDR_W-1:0] a);
        t_pitch_idx                  pi;
        bit                          mr;
        bit                          pr;
        logic [rmsg_pkg::ADDR_W-1:0] ma;
        logic [rmsg_pkg::ADDR_W-1:0] pa;
        void'(sb.next_state(sb.regs, rmsg_pkg::t_in_word'{f, d, a}, mr, ma, pr, pi));
        if (mr && !sb.melody_set[ma])
            send_word(rmsg_pkg::FUNC_LOAD_MEL, rmsg_pkg::DATA_W'($urandom), ma);
        if (pr && !sb.pitch_set[pi]) begin
            pa = rmsg_pkg::ADDR_W'($urandom);
            pa[$bits(pi)-1:0] = pi;
            send_word(rmsg_pkg::FUNC_LOAD_PITCH, random_pitch(), pa);
        end
        send_word(f, d, a);
    endtask

    // Field extremes, every func, hold, manual edge, quiet reload, ignored codes.
    task automatic run_directed();
        send_item(rmsg_pkg::FUNC_LOAD_PITCH, 8'hfe, 11'h7e0);
        send_item(rmsg_pkg::FUNC_LOAD_PITCH, 8'hff, 11'h01f);    // quiet reload entry
        send_item(rmsg_pkg::FUNC_LOAD_MEL,   8'h3f, 11'h000);    // timer running, pitch 31
        send_item(rmsg_pkg::FUNC_LOAD_MEL,   8'h21, 11'h001);
        send_item(rmsg_pkg::FUNC_LOAD_MEL,   8'hff, 11'h7ff);
        send_item(rmsg_pkg::FUNC_LOAD_MEL,   8'h00, 11'h780);
        send_item(rmsg_pkg::FUNC_CTRL,       8'h20, 11'h000);    // auto, block 0
        send_item(rmsg_pkg::FUNC_AUTO,       8'h00, 11'h000);
        send_item(rmsg_pkg::FUNC_AUTO,       8'hff, 11'h7ff);
        send_item(rmsg_pkg::FUNC_SAMPLE,     8'h00, 11'h000);
        send_item(rmsg_pkg::FUNC_CTRL,       8'h0f, 11'h000);    // manual, top block
        send_item(rmsg_pkg::FUNC_CTRL,       8'h4f, 11'h000);    // rising manual edge steps
        send_item(rmsg_pkg::FUNC_CTRL,       8'h4f, 11'h000);    // no edge, no step
        send_item(rmsg_pkg::FUNC_CTRL,       8'h1f, 11'h000);    // hold clears low bits
        send_item(rmsg_pkg::FUNC_SAMPLE,     8'hff, 11'h7ff);    // held: divider frozen
        send_item(rmsg_pkg::FUNC_AUTO,       8'h00, 11'h000);    // held: no step
        send_item(rmsg_pkg::FUNC_CTRL,       8'h5f, 11'h000);    // manual edge under hold
        send_item(rmsg_pkg::FUNC_CTRL,       8'h3f, 11'h000);
        send_item(rmsg_pkg::FUNC_AUTO,       8'h00, 11'h000);
        send_item(FUNC_SPARE_A,              8'hff, 11'h7ff);
        send_item(FUNC_SPARE_B,              8'h00, 11'h000);
        send_item(FUNC_SPARE_C,              8'haa, 11'h555);
        send_item(rmsg_pkg::FUNC_CTRL,       8'hff, 11'h7ff);
        send_item(rmsg_pkg::FUNC_CTRL,       8'h00, 11'h000);
    endtask

    // Mostly sample ticks so the divider wraps and the square runs; control writes
    // favor manual edges on the current block; loads favor the block being walked.
    task automatic random_item();
        int                          pick;
        logic [rmsg_pkg::FUNC_W-1:0] f;
        logic [rmsg_pkg::DATA_W-1:0] d;
        logic [rmsg_pkg::ADDR_W-1:0] a;
        pick = $urandom_range(99);
        d    = rmsg_pkg::DATA_W'($urandom);
        a    = rmsg_pkg::ADDR_W'($urandom);
        if (pick < 45) begin
            f = rmsg_pkg::FUNC_SAMPLE;
        end else if (pick < 63) begin
            f = rmsg_pkg::FUNC_AUTO;
        end else if (pick < 81) begin
            f = rmsg_pkg::FUNC_CTRL;
            if ($urandom_range(1) == 0) begin
                // manual step: flip the edge bit on the current setting
                d = sb.regs.ctrl ^ rmsg_pkg::DATA_W'(1 << rmsg_pkg::BIT_MAN_CLK);
                d[rmsg_pkg::BIT_AUTO] = 1'b0;
                d[rmsg_pkg::BIT_HOLD] = 1'b0;
            end else if ($urandom_range(7) != 0) begin
                d[rmsg_pkg::BIT_HOLD] = 1'b0;
            end
        end else if (pick < 91) begin
            f = rmsg_pkg::FUNC_LOAD_MEL;
            if ($urandom_range(2) != 0)
                a[rmsg_pkg::ADDR_W-1:rmsg_pkg::ADDR_LO_W] =
                    sb.regs.addr[rmsg_pkg::ADDR_W-1:rmsg_pkg::ADDR_LO_W];
        end else if (pick < 96) begin
            f = rmsg_pkg::FUNC_LOAD_PITCH;
            d = random_pitch();
        end else begin
            case ($urandom_range(2))
                0:       f = FUNC_SPARE_A;
                1:       f = FUNC_SPARE_B;
                default: f = FUNC_SPARE_C;
            endcase
        end
        send_item(f, d, a);
    endtask

    initial begin
        int phase;
        in_ch.valid        = 1'b0;
        in_ch.func         = rmsg_pkg::FUNC_CTRL;
        in_ch.data         = '0;
        in_ch.load_address = '0;
        i_rst_n            = 1'b0;
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    // back-pressure burst while the sender runs flat out
                    hold_off_left      = LONG_HOLD_OFF;
                end
                1: begin
                    sender_idle_pct    = 74;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 74;
                end
                default: begin
                    sender_idle_pct    = 14;
                    receiver_stall_pct = 14;
                end
            endcase
            repeat (WORDS_PER_PHASE) random_item();
        end
        in_ch.valid = 1'b0;

        while (sb.expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Coverage: %0d input words, %0d results checked, %0d square toggles,",
                 words_sent, sb.checked, sb.toggles);
        $display("  over free-running, idle-sender, stalled-receiver and mixed pacing.");
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
